### rtl/fpm_pkg.sv
// ============================================================================
// fpm_pkg: shared definitions for the file name pattern matcher
// Opcodes, flag bit positions, port widths and the ASCII case fold helper.
// ============================================================================
package fpm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam int unsigned NAME_MAX_DEF    = 256;

  // Port widths fixed by the item format.
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned FLAGS_W    = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  // Bit positions inside the match flags register.
  localparam int unsigned FLAG_FOLD     = 0;
  localparam int unsigned FLAG_EXACT    = 1;
  localparam int unsigned FLAG_KEEP_EXT = 2;

  localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2
  } op_t;

  // Per-beat controls broadcast to every cell of the chain.
  typedef struct packed {
    logic append;   // write the beat's byte into the first cell past the pattern tail
    logic restart;  // return name state to its idle values
    logic step;     // a name byte that is inside the length limit
    logic fold;     // ASCII lowercase both strings before comparing
  } fpm_ctrl_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic              en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (en && c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

### rtl/fpm_cell.sv
// ============================================================================
// fpm_cell: one pattern position of the matching chain
// Holds one pattern byte, one shift-and bit and one exact-prefix bit.
// ============================================================================
module fpm_cell #(
  parameter int unsigned PATTERN_MAX = fpm_pkg::PATTERN_MAX_DEF,
  parameter int unsigned IDX         = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fpm_pkg::fpm_ctrl_t                    ctrl,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]      plen,
  input  logic [fpm_pkg::CHAR_W-1:0]            char_raw,
  input  logic [fpm_pkg::CHAR_W-1:0]            char_f,
  input  logic                                  pm_in,
  input  logic                                  ex_in,
  output logic                                  pm_out,
  output logic                                  ex_out,
  output logic                                  tail_hit,
  output logic                                  tail_pref
);
  import fpm_pkg::*;

  localparam int unsigned PLEN_W = $clog2(PATTERN_MAX + 1);

  logic [CHAR_W-1:0] pat_r;
  logic              pm_r;
  logic              ex_r;
  logic              in_pattern;
  logic              is_tail;
  logic              eq;
  logic              pm_nxt;
  logic              ex_nxt;

  assign in_pattern = plen > PLEN_W'(IDX);
  assign is_tail    = plen == PLEN_W'(IDX + 1);
  assign eq         = fold_char(pat_r, ctrl.fold) == char_f;
  assign pm_nxt     = pm_in & eq & in_pattern;
  assign ex_nxt     = ex_in & eq & in_pattern;
  assign tail_hit   = ctrl.step & is_tail & pm_nxt;
  assign tail_pref  = ctrl.step & is_tail & ex_nxt;
  assign pm_out     = pm_r;
  assign ex_out     = ex_r;

  always_ff @(posedge clk) begin
    if (ctrl.append && plen == PLEN_W'(IDX)) begin
      pat_r <= char_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r <= 1'b0;
      ex_r <= 1'b0;
    end else if (ctrl.restart) begin
      pm_r <= 1'b0;
      ex_r <= 1'b0;
    end else if (ctrl.step) begin
      pm_r <= pm_nxt;
      ex_r <= ex_nxt;
    end
  end

endmodule

### rtl/fpm_cell_chain.sv
// ============================================================================
// fpm_cell_chain: row of pattern cells
// Links the cells bit to bit and gathers the hit flags of the tail cell.
// ============================================================================
module fpm_cell_chain #(
  parameter int unsigned PATTERN_MAX = fpm_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fpm_pkg::fpm_ctrl_t               ctrl,
  input  logic [$clog2(PATTERN_MAX+1)-1:0] plen,
  input  logic [fpm_pkg::CHAR_W-1:0]       char_raw,
  input  logic [fpm_pkg::CHAR_W-1:0]       char_f,
  output logic                             full_hit,
  output logic                             pref_hit
);
  import fpm_pkg::*;

  logic [PATTERN_MAX:0]   pm_w;
  logic [PATTERN_MAX:0]   ex_w;
  logic [PATTERN_MAX-1:0] hit_v;
  logic [PATTERN_MAX-1:0] pref_v;
  logic                   ex0_r;

  // The empty prefix always matches for the substring search; for the
  // exact-prefix check it only holds before the first name byte.
  assign pm_w[0] = 1'b1;
  assign ex_w[0] = ex0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex0_r <= 1'b1;
    end else if (ctrl.restart) begin
      ex0_r <= 1'b1;
    end else if (ctrl.step) begin
      ex0_r <= 1'b0;
    end
  end

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    fpm_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .IDX         (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .plen      (plen),
      .char_raw  (char_raw),
      .char_f    (char_f),
      .pm_in     (pm_w[g]),
      .ex_in     (ex_w[g]),
      .pm_out    (pm_w[g+1]),
      .ex_out    (ex_w[g+1]),
      .tail_hit  (hit_v[g]),
      .tail_pref (pref_v[g])
    );
  end

  assign full_hit = |hit_v;
  assign pref_hit = |pref_v;

  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_v))
    else $error("more than one cell reports a full pattern hit");
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(pref_v))
    else $error("more than one cell reports an exact prefix hit");
  assert property (@(posedge clk) disable iff (!rst_n)
                   ctrl.restart |=> ex0_r)
    else $error("empty exact prefix not restored after restart");

endmodule

### rtl/file_name_pattern_matcher.sv
// ============================================================================
// file_name_pattern_matcher: streaming file name pattern matcher
// Result: formed as a name's last byte is accepted, then registered (output or skid).
// Throughput: one beat per cycle, pattern and name bytes alike, while the skid register is empty.
// Reset (rst_n low, synchronous): empty pattern, flags zero, name state idle,
// output and skid stages empty. Pattern bytes themselves are not cleared.
// ============================================================================
//
// Operation
//   The pattern lives in a row of cells, one per pattern position. Each cell
//   holds its byte and one bit of the shift-and vector; on every name byte
//   the bit of cell j becomes the previous bit of cell j-1 ANDed with the
//   compare of its own byte against the incoming character. A second chain
//   of bits, seeded only at the start of a name, tracks whether the name so
//   far equals the pattern as a prefix.
//
//   The cell at the pattern tail reports a full hit. The top level keeps the
//   name position, the end of the first full hit, the last dot and an
//   overflow mark, and on the beat with tlast forms the result from the
//   updated state in the same cycle.
//
//   A clear or append beat also abandons the name in progress. Name bytes
//   beyond NAME_MAX are dropped except for their tlast mark and set the
//   too-long flag.
//
//   The result side has an output register plus one skid register, so input
//   beats keep flowing while a finished result waits; tready drops only when
//   both hold results.
module file_name_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = fpm_pkg::PATTERN_MAX_DEF,
  parameter int unsigned NAME_MAX    = fpm_pkg::NAME_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fpm_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] char_code
  input  logic [fpm_pkg::OP_W-1:0]          in_tuser,   // [1:0] op
  input  logic                              in_tlast,   // last_char
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fpm_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] name_matches,
                                                        // [1] name_too_long, rest 0
  // Configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpm_pkg::FLAGS_W-1:0]       cfg_data    // match_flags
);
  import fpm_pkg::*;

  localparam int unsigned PLEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned POS_W  = $clog2(NAME_MAX + 1);
  localparam int unsigned CMP_W  = (POS_W > PLEN_W) ? POS_W : PLEN_W;

  // Configuration and pattern length.
  logic [FLAGS_W-1:0] flags_r;
  logic [PLEN_W-1:0]  plen_r;

  // Name state.
  logic [POS_W-1:0]   pos_r,      pos_nxt;
  logic               found_r,    found_nxt;
  logic [POS_W-1:0]   fme_r,      fme_nxt;
  logic               dot_seen_r, dot_seen_nxt;
  logic [POS_W-1:0]   dot_pos_r,  dot_pos_nxt;
  logic               pref_ok_r,  pref_ok_nxt;
  logic               ovf_r,      ovf_nxt;

  // Result stages.
  logic               out_valid_r;
  logic               out_match_r;
  logic               out_long_r;
  logic               skid_valid_r;
  logic               skid_match_r;
  logic               skid_long_r;

  // Beat decode.
  op_t                op;
  logic               is_clear;
  logic               is_append;
  logic               is_name;
  logic               in_accept;
  logic               name_active;
  logic               finish;
  fpm_ctrl_t          ctrl;
  logic [CHAR_W-1:0]  char_f;
  logic               full_hit;
  logic               pref_hit;

  // Result forming.
  logic [POS_W-1:0]   cut;
  logic               res_match;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid & in_tready;
  assign op        = op_t'(in_tuser);

  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_name   = 1'b0;
    unique case (op)
      OP_CLEAR:  is_clear  = 1'b1;
      OP_APPEND: is_append = 1'b1;
      OP_NAME:   is_name   = 1'b1;
      default:   ;
    endcase
  end

  assign name_active  = pos_r < POS_W'(NAME_MAX);
  assign finish       = in_accept & is_name & in_tlast;
  assign char_f       = fold_char(in_tdata, flags_r[FLAG_FOLD]);

  assign ctrl.append  = in_accept & is_append & (plen_r < PLEN_W'(PATTERN_MAX));
  assign ctrl.restart = (in_accept & (is_clear | is_append)) | finish;
  assign ctrl.step    = in_accept & is_name & name_active;
  assign ctrl.fold    = flags_r[FLAG_FOLD];

  fpm_cell_chain #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .plen     (plen_r),
    .char_raw (in_tdata),
    .char_f   (char_f),
    .full_hit (full_hit),
    .pref_hit (pref_hit)
  );

  // Name state after this beat, before any restart.
  always_comb begin
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    fme_nxt      = fme_r;
    dot_seen_nxt = dot_seen_r;
    dot_pos_nxt  = dot_pos_r;
    pref_ok_nxt  = pref_ok_r;
    ovf_nxt      = ovf_r;
    if (in_accept && is_name) begin
      if (!name_active) begin
        ovf_nxt = 1'b1;
      end else begin
        if (in_tdata == DOT_CHAR) begin
          dot_seen_nxt = 1'b1;
          dot_pos_nxt  = pos_r;
        end
        pos_nxt = pos_r + POS_W'(1);
        if (plen_r != '0 && !found_r && full_hit) begin
          found_nxt = 1'b1;
          fme_nxt   = pos_r + POS_W'(1);
        end
        if (pref_hit) begin
          pref_ok_nxt = 1'b1;
        end
      end
    end
  end

  // The name is cut at its last dot unless extensions are kept. An empty
  // pattern counts as an exact prefix of every name.
  always_comb begin
    cut = pos_nxt;
    if (!flags_r[FLAG_KEEP_EXT] && dot_seen_nxt) begin
      cut = dot_pos_nxt;
    end
    if (flags_r[FLAG_EXACT]) begin
      res_match = (pref_ok_nxt || plen_r == '0) && CMP_W'(cut) == CMP_W'(plen_r);
    end else if (plen_r == '0) begin
      res_match = 1'b1;
    end else begin
      res_match = found_nxt && fme_nxt <= cut;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      plen_r     <= '0;
      pos_r      <= '0;
      found_r    <= 1'b0;
      fme_r      <= '0;
      dot_seen_r <= 1'b0;
      dot_pos_r  <= '0;
      pref_ok_r  <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        flags_r <= cfg_data;
      end
      if (in_accept && is_clear) begin
        plen_r <= '0;
      end else if (ctrl.append) begin
        plen_r <= plen_r + PLEN_W'(1);
      end
      if (ctrl.restart) begin
        pos_r      <= '0;
        found_r    <= 1'b0;
        fme_r      <= '0;
        dot_seen_r <= 1'b0;
        dot_pos_r  <= '0;
        pref_ok_r  <= 1'b0;
        ovf_r      <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        found_r    <= found_nxt;
        fme_r      <= fme_nxt;
        dot_seen_r <= dot_seen_nxt;
        dot_pos_r  <= dot_pos_nxt;
        pref_ok_r  <= pref_ok_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  // Output register with one skid entry behind it. A new result can only
  // arrive while the skid entry is empty, since tready follows it.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= finish;
      end
    end else if (finish) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_match_r <= skid_match_r;
        out_long_r  <= skid_long_r;
      end else if (finish) begin
        out_match_r <= res_match;
        out_long_r  <= ovf_nxt;
      end
    end else if (finish) begin
      skid_match_r <= res_match;
      skid_long_r  <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2){1'b0}}, out_long_r, out_match_r};

  // A result only waits in the skid entry behind a stalled output register.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  // The first full hit lies inside the part of the name seen so far.
  assert property (@(posedge clk) disable iff (!rst_n)
                   found_r |-> (fme_r != '0 && fme_r <= pos_r))
    else $error("first match end outside the name seen so far");

  // Overflow is only flagged once the position has reached the limit.
  assert property (@(posedge clk) disable iff (!rst_n)
                   ovf_r |-> pos_r == POS_W'(NAME_MAX))
    else $error("name overflow flagged below the length limit");

  // The pattern never grows past the number of cells.
  assert property (@(posedge clk) disable iff (!rst_n)
                   plen_r <= PLEN_W'(PATTERN_MAX))
    else $error("pattern length beyond the cell count");

  // After a name's last byte the output register always holds a result on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) finish |=> out_valid_r)
    else $error("finished name produced no result");

endmodule

### verif/file_name_pattern_matcher_test.sv
`timescale 1ns / 1ps
// ============================================================================
// file_name_pattern_matcher_test: self-checking bench for the name matcher
// Streams pattern edits and file names under every flag setting. A
// shift-and predictor inside the bench computes each name's verdict, and
// the result stream is checked against it beat by beat, with random idle
// cycles on both sides.
// ============================================================================
module file_name_pattern_matcher_test;
  import fpm_pkg::*;

  // Sizes of the instance under test (package defaults).
  localparam int PAT_MAX    = PATTERN_MAX_DEF;
  localparam int NAME_LIMIT = NAME_MAX_DEF;

  // The opcode that the block ignores. It has no member in op_t.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  // Cycles allowed after the last result before the flags are rewritten or
  // the run ends. The result is registered, so this margin is plenty.
  localparam int SETTLE_CYCLES = 4;

  // The least number of input beats that each random phase sends.
  localparam int PHASE_BEATS = 35;
  localparam int NUM_PHASES  = 10;

  // One result beat as the bench sees it.
  typedef struct packed {
    logic hit;
    logic too_long;
  } verdict_t;

  // One row of the directed stimulus. Rows with known_result set carry a
  // verdict typed in by hand; all other rows are checked against the
  // predictor.
  typedef struct {
    logic [FLAGS_W-1:0] flags;
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  ch;
    logic               last;
    bit                 known_result;
    verdict_t           known_verdict;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] char_code
  logic [OP_W-1:0]       in_tuser;   // [1:0] op
  logic                  in_tlast;   // last_char
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] name_matches, [1] name_too_long
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [FLAGS_W-1:0]    cfg_data;   // match_flags

  file_name_pattern_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: the bench's own copy of the pattern, the flags and the
  // per-name tracking registers.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0]  pat_bytes [PAT_MAX];
  int                 pat_len;
  logic [PAT_MAX:0]   prefix_hits;   // bit j: the last j name bytes equal pattern[0..j-1]
  int                 name_pos;
  bit                 hit_seen;
  int                 hit_end;
  bit                 dot_seen;
  int                 dot_pos;
  bit                 exact_ok;
  bit                 name_overflow;
  logic [FLAGS_W-1:0] flags_now;

  verdict_t verdicts_due[$];
  int       fail_count;
  int       beats_sent;
  bit       idle_on;  // when clear, neither side inserts idle cycles

  // ASCII lowercase, applied only while the fold flag is set.
  function automatic logic [CHAR_W-1:0] lower_if(input logic [CHAR_W-1:0] c);
    if (flags_now[FLAG_FOLD] && c >= 8'h41 && c <= 8'h5A) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  task automatic name_reset();
    prefix_hits   = '0;
    prefix_hits[0] = 1'b1;
    name_pos      = 0;
    hit_seen      = 1'b0;
    hit_end       = 0;
    dot_seen      = 1'b0;
    dot_pos       = 0;
    exact_ok      = 1'b1;
    name_overflow = 1'b0;
  endtask

  // Updates the predictor with one accepted beat and says whether it ends a
  // name, and with which verdict.
  task automatic match_predict(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                               input logic last, output bit has_result,
                               output verdict_t v);
    logic [CHAR_W-1:0] c;
    int                cut;
    has_result = 1'b0;
    v          = '0;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        name_reset();
      end
      OP_APPEND: begin
        // A full pattern silently drops further appends.
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = ch;
          pat_len++;
        end
        name_reset();
      end
      OP_NAME: begin
        c = lower_if(ch);
        if (name_pos >= NAME_LIMIT) begin
          name_overflow = 1'b1;
        end else begin
          if (ch == DOT_CHAR) begin
            dot_seen = 1'b1;
            dot_pos  = name_pos;
          end
          if (name_pos < pat_len && lower_if(pat_bytes[name_pos]) != c) begin
            exact_ok = 1'b0;
          end
          for (int j = pat_len; j >= 1; j--) begin
            prefix_hits[j] = prefix_hits[j-1] && (lower_if(pat_bytes[j-1]) == c);
          end
          prefix_hits[0] = 1'b1;
          name_pos++;
          if (pat_len > 0 && !hit_seen && prefix_hits[pat_len]) begin
            hit_seen = 1'b1;
            hit_end  = name_pos;
          end
        end
        if (last) begin
          // Without the keep-extension flag the name ends before its last dot.
          cut = name_pos;
          if (!flags_now[FLAG_KEEP_EXT] && dot_seen) begin
            cut = dot_pos;
          end
          if (flags_now[FLAG_EXACT]) begin
            v.hit = exact_ok && (cut == pat_len);
          end else if (pat_len == 0) begin
            v.hit = 1'b1;
          end else begin
            // The first full match must end inside the cut name.
            v.hit = hit_seen && (hit_end <= cut);
          end
          v.too_long = name_overflow;
          has_result = 1'b1;
          name_reset();
        end
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Called at a falling edge, returns at a falling edge. The
  // beat's valid stays high into the next call unless an idle cycle is drawn,
  // so valid is never lowered and raised in the same time step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic last, input bit known_result,
                           input verdict_t known_verdict);
    bit       has_result;
    verdict_t v;
    while (idle_on && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    match_predict(op, ch, last, has_result, v);
    if (has_result) begin
      verdicts_due = {verdicts_due, known_result ? known_verdict : v};
    end
    if (op != OP_IGNORED) begin
      beats_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic last);
    send_beat(op, ch, last, 1'b0, '0);
  endtask

  // Waits until every result is in and the block has settled, then writes
  // the flags. This is also the point where the sender holds off entirely.
  task automatic apply_flags(input logic [FLAGS_W-1:0] f);
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (!cfg_ready);
    flags_now = f;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random content helpers. The alphabet leans on letters of both cases and
  // the dot, so that folding and extension cuts matter often.
  // --------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 7))
      0: return 8'h61;       // 'a'
      1: return 8'h62;       // 'b'
      2: return 8'h41;       // 'A'
      3: return 8'h42;       // 'B'
      4: return DOT_CHAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic send_pattern(input int len);
    send_plain(OP_CLEAR, pick_char(), 1'($urandom_range(0, 1)));
    for (int i = 0; i < len; i++) begin
      send_plain(OP_APPEND, pick_char(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Builds a name around the current pattern: an optional short prefix, usually
  // the pattern itself (sometimes with flipped case or one corrupted byte), an
  // optional extension and tail and, for over-long names, padding past the limit.
  task automatic send_name(input bit over_long);
    logic [CHAR_W-1:0] buf_q[$];
    int                pad_to;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) buf_q = {buf_q, pick_char()};
    end
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < pat_len; i++) begin
        buf_q = {buf_q, $urandom_range(0, 1) ? flip_case(pat_bytes[i]) : pat_bytes[i]};
      end
      if (pat_len > 0 && $urandom_range(0, 5) == 0) begin
        buf_q[$urandom_range(0, buf_q.size() - 1)] = pick_char();
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      buf_q = {buf_q, DOT_CHAR};
      repeat ($urandom_range(0, 3)) buf_q = {buf_q, pick_char()};
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) buf_q = {buf_q, pick_char()};
    end
    if (over_long) begin
      pad_to = $urandom_range(NAME_LIMIT + 1, NAME_LIMIT + 40);
      while (buf_q.size() < pad_to) begin
        buf_q.insert(0, pick_char());
      end
    end
    if (buf_q.size() == 0) begin
      buf_q = {buf_q, pick_char()};
    end
    for (int i = 0; i < buf_q.size(); i++) begin
      send_plain(OP_NAME, buf_q[i], i == buf_q.size() - 1);
    end
  endtask

  // One phase of random traffic under fixed flags. Most of it is pattern
  // setup followed by well-formed names; the rest is noise and names cut
  // short by a pattern edit.
  task automatic run_phase(input logic [FLAGS_W-1:0] f, input bit force_extremes);
    int start;
    int r;
    apply_flags(f);
    start = beats_sent;
    if (force_extremes) begin
      // Overfill the pattern, then run one name past the length limit.
      send_pattern(PAT_MAX + 3);
      send_name(1'b1);
      send_pattern(2);
    end
    while (beats_sent - start < PHASE_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_pattern(($urandom_range(0, 19) == 0) ? $urandom_range(PAT_MAX - 4, PAT_MAX + 6)
                                                 : $urandom_range(0, 5));
      end else if (r < 80) begin
        send_name($urandom_range(0, 99) == 0);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) begin
          send_plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_plain(OP_NAME, pick_char(), 1'b0);
        if ($urandom_range(0, 1)) begin
          send_pattern($urandom_range(0, 4));
        end else begin
          send_plain(OP_APPEND, pick_char(), 1'($urandom_range(0, 1)));
        end
      end
    end
    // Close any name left open so that the next flag write finds the block idle.
    send_plain(OP_NAME, pick_char(), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the checker.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("result beat 0x%0h arrived with no name pending", out_tdata);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_tdata[0] !== want.hit) begin
          $error("name_matches: expected %0b, actual %0b", want.hit, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== want.too_long) begin
          $error("name_too_long: expected %0b, actual %0b", want.too_long, out_tdata[1]);
          fail_count++;
        end
        if (out_tdata[OUT_DATA_W-1:2] !== '0) begin
          $error("tdata padding: expected 0, actual 0x%0h", out_tdata[OUT_DATA_W-1:2]);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed rows. Apart from the two verdicts typed in, every row relies
  // on the predictor.
  // --------------------------------------------------------------------------
  directed_row_t directed_rows[25];

  initial begin
    directed_rows = '{
      // Empty pattern in substring mode always matches.
      '{3'd0, OP_NAME,    8'h61, 1'b1, 1'b1, '{1'b1, 1'b0}},
      // The unused opcode is dropped without a result.
      '{3'd0, OP_IGNORED, 8'h7A, 1'b1, 1'b0, '0},
      // Byte extremes in the pattern and in the name.
      '{3'd0, OP_APPEND,  8'hFF, 1'b0, 1'b0, '0},
      '{3'd0, OP_APPEND,  8'h00, 1'b1, 1'b0, '0},
      '{3'd0, OP_NAME,    8'hFF, 1'b0, 1'b0, '0},
      '{3'd0, OP_NAME,    8'h00, 1'b1, 1'b0, '0},
      // A match that lies wholly inside the cut-off extension does not count.
      '{3'd0, OP_CLEAR,   8'h00, 1'b0, 1'b0, '0},
      '{3'd0, OP_APPEND,  8'h61, 1'b0, 1'b0, '0},
      '{3'd0, OP_NAME,    DOT_CHAR, 1'b0, 1'b0, '0},
      '{3'd0, OP_NAME,    8'h61, 1'b1, 1'b0, '0},
      // A pattern edit in the middle of a name abandons that name.
      '{3'd0, OP_APPEND,  8'h42, 1'b0, 1'b0, '0},
      '{3'd0, OP_NAME,    8'h78, 1'b0, 1'b0, '0},
      '{3'd0, OP_APPEND,  8'h63, 1'b0, 1'b0, '0},
      // Case folding: "AbC" against the pattern "aBc".
      '{3'd1, OP_NAME,    8'h41, 1'b0, 1'b0, '0},
      '{3'd1, OP_NAME,    8'h62, 1'b0, 1'b0, '0},
      '{3'd1, OP_NAME,    8'h43, 1'b1, 1'b0, '0},
      // Exact match with folding.
      '{3'd3, OP_NAME,    8'h61, 1'b0, 1'b0, '0},
      '{3'd3, OP_NAME,    8'h62, 1'b0, 1'b0, '0},
      '{3'd3, OP_NAME,    8'h63, 1'b1, 1'b0, '0},
      // Empty pattern in exact mode: "." is cut to nothing and matches.
      '{3'd2, OP_CLEAR,   8'hFF, 1'b1, 1'b0, '0},
      '{3'd2, OP_NAME,    DOT_CHAR, 1'b1, 1'b1, '{1'b1, 1'b0}},
      // Keeping the extension leaves "." whole, so it no longer matches.
      '{3'd6, OP_NAME,    DOT_CHAR, 1'b1, 1'b0, '0},
      // All flags set.
      '{3'd7, OP_APPEND,  8'h5A, 1'b0, 1'b0, '0},
      '{3'd7, OP_NAME,    8'h7A, 1'b1, 1'b0, '0},
      // Folding off: "q" against "Z".
      '{3'd4, OP_NAME,    8'h71, 1'b1, 1'b0, '0}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [FLAGS_W-1:0] phase_flags[NUM_PHASES];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_CLEAR;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    fail_count = 0;
    beats_sent = 0;
    idle_on    = 1'b1;
    flags_now  = '0;
    pat_len    = 0;
    name_reset();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Write the flags once right after reset, then walk the directed rows,
    // rewriting the flags whenever a row asks for different ones.
    apply_flags(3'd0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].flags != flags_now) begin
        apply_flags(directed_rows[i].flags);
      end
      send_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].last,
                directed_rows[i].known_result, directed_rows[i].known_verdict);
    end

    // Random phases: the extremes of the flags first, then every other
    // value, then random settings. One phase runs with no idle cycles.
    phase_flags = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0};
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p >= 8) begin
        phase_flags[p] = 3'($urandom_range(0, 7));
      end
      idle_on = (p != 4);
      run_phase(phase_flags[p], p == 0);
    end
    idle_on = 1'b1;

    // Drain: nothing more is sent; wait for every result, then for the settle
    // margin, so that a stray extra beat would still be caught.
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every stall drawn.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
